/* sv/llrb_pkg.sv */
// Shared types and constants of the Laplacian row builder.
`default_nettype none
package llrb_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int DIMENSIONS = 3;

    localparam logic [2:0] P_RESET = 3'd2;
    localparam logic [2:0] P_MAX   = 3'd4;

    localparam logic [47:0] MAG_LIMIT = 48'h8000_0000_0000;
    localparam logic [47:0] SUM_MAX   = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [9:0]         row_index;
        logic [9:0]         col_index;
        logic [23:0]        distance;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic               last_in_row;
    } t_cell;

    typedef struct packed {
        logic [9:0]         out_row;
        logic [9:0]         out_col;
        logic signed [47:0] entry_value;
        logic               saturated;
        logic               last_of_row;
    } t_entry;

endpackage
`default_nettype wire

/* sv/layout_laplacian_row_builder.sv */
// Top level: bit-serial Laplacian row builder for stress majorization.
//
//  channel  | direction | handshake                    | payload
//  cell     | in        | i_cell_valid / o_cell_ready  | i_cell  (llrb_pkg::t_cell)
//  entry    | out       | o_entry_valid / i_entry_ready| o_entry (llrb_pkg::t_entry)
//  cfg      | in        | i_cfg_valid / o_cfg_ready    | i_cfg_data (distance exponent)
//
// An off-diagonal cell goes through shift-add squaring of each dimension, a square root,
// p-1 shift-add multiplications (p capped at P_MAX) and a restoring division.
// Other cells skip these steps; a cell that is last in its row adds a diagonal transfer.
// One cell is worked on at a time; the entry register holds a result until taken.
// Synchronous active-low reset clears control and diagonal sum and sets the exponent to its default.
`default_nettype none
module layout_laplacian_row_builder (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cell_valid,
    output logic                 o_cell_ready,
    input  wire llrb_pkg::t_cell i_cell,
    output logic                 o_entry_valid,
    input  wire logic            i_entry_ready,
    output llrb_pkg::t_entry     o_entry,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [2:0]      i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQ     = 3'd1;
    localparam logic [2:0] S_SQRT   = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_EMIT_E = 3'd6;
    localparam logic [2:0] S_EMIT_D = 3'd7;

    localparam logic [1:0] LAST_DIM = 2'(llrb_pkg::DIMENSIONS - 1);
    localparam logic [10:0] NODES   = 11'(llrb_pkg::MAX_NODES);

    logic [2:0]       r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;
    logic [1:0]       r_dim, n_dim;
    llrb_pkg::t_cell  r_in, n_in;
    logic [2:0]       r_p, n_p;
    logic [2:0]       r_pe, n_pe;
    logic [65:0]      r_prod, n_prod;
    logic [66:0]      r_sum_sq, n_sum_sq;
    logic [69:0]      r_sqsh, n_sqsh;
    logic [34:0]      r_root, n_root;
    logic [37:0]      r_rem, n_rem;
    logic [106:0]     r_den, n_den;
    logic [106:0]     r_acc, n_acc;
    logic [2:0]       r_mulk, n_mulk;
    logic [80:0]      r_num, n_num;
    logic [106:0]     r_rq, n_rq;
    logic [48:0]      r_q, n_q;
    logic             r_qovf, n_qovf;
    logic [47:0]      r_mag, n_mag;
    logic             r_clip, n_clip;
    logic [47:0]      r_dsum, n_dsum;
    logic             r_dclip, n_dclip;
    llrb_pkg::t_entry r_out, n_out;
    logic             r_ovalid, n_ovalid;

    logic signed [32:0] w_diff;
    logic [32:0]        w_abs;
    logic [65:0]        w_prod;
    logic [37:0]        w_rem_sh, w_trial;
    logic [106:0]       w_acc;
    logic [107:0]       w_rs, w_rs_sub;
    logic               w_ge;
    logic [48:0]        w_qf;
    logic               w_qovf;
    logic [48:0]        w_dsum;
    logic               w_out_free;
    logic               w_offdiag;

    assign o_cell_ready  = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_entry_valid = r_ovalid;
    assign o_entry       = r_out;
    assign w_out_free    = !r_ovalid || i_entry_ready;
    assign w_offdiag     = (i_cell.row_index != i_cell.col_index)
                         && ({1'b0, i_cell.row_index} < NODES)
                         && ({1'b0, i_cell.col_index} < NODES);

    always_comb begin
        unique case (r_dim)
            2'd0:    w_diff = 33'(r_in.first_x) - 33'(r_in.second_x);
            2'd1:    w_diff = 33'(r_in.first_y) - 33'(r_in.second_y);
            2'd2:    w_diff = 33'(r_in.first_z) - 33'(r_in.second_z);
            default: w_diff = '0;
        endcase
    end
    assign w_abs  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_prod = {r_prod[64:0], 1'b0} + (w_abs[r_cnt[5:0]] ? {33'b0, w_abs} : 66'b0);

    assign w_rem_sh = {r_rem[35:0], r_sqsh[69:68]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    assign w_acc = {r_acc[105:0], 1'b0} + (r_in.distance[r_cnt[4:0]] ? r_den : 107'b0);

    assign w_rs     = {r_rq, r_num[80]};
    assign w_ge     = w_rs >= {1'b0, r_den};
    assign w_rs_sub = w_rs - {1'b0, r_den};
    assign w_qf     = {r_q[47:0], w_ge};
    assign w_qovf   = r_qovf || r_q[48];

    assign w_dsum = {1'b0, r_dsum} + {1'b0, r_mag};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dim    = r_dim;
        n_in     = r_in;
        n_p      = r_p;
        n_pe     = r_pe;
        n_prod   = r_prod;
        n_sum_sq = r_sum_sq;
        n_sqsh   = r_sqsh;
        n_root   = r_root;
        n_rem    = r_rem;
        n_den    = r_den;
        n_acc    = r_acc;
        n_mulk   = r_mulk;
        n_num    = r_num;
        n_rq     = r_rq;
        n_q      = r_q;
        n_qovf   = r_qovf;
        n_mag    = r_mag;
        n_clip   = r_clip;
        n_dsum   = r_dsum;
        n_dclip  = r_dclip;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_entry_ready;

        if (i_cfg_valid) begin
            n_p = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cell_valid) begin
                    n_in     = i_cell;
                    n_pe     = (r_p > llrb_pkg::P_MAX) ? llrb_pkg::P_MAX : r_p;
                    n_prod   = '0;
                    n_sum_sq = '0;
                    n_dim    = '0;
                    n_cnt    = 7'd32;
                    if (w_offdiag) begin
                        n_state = S_SQ;
                    end else if (i_cell.last_in_row) begin
                        n_state = S_EMIT_D;
                    end
                end
            end
            S_SQ: begin
                n_prod = w_prod;
                n_cnt  = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_sum_sq = r_sum_sq + {1'b0, w_prod};
                    n_prod   = '0;
                    n_cnt    = 7'd32;
                    n_dim    = r_dim + 2'd1;
                    if (r_dim == LAST_DIM) begin
                        n_sqsh  = {3'b0, n_sum_sq};
                        n_root  = '0;
                        n_rem   = '0;
                        n_cnt   = 7'd34;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                n_sqsh = {r_sqsh[67:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    n_rem  = w_rem_sh - w_trial;
                    n_root = {r_root[33:0], 1'b1};
                end else begin
                    n_rem  = w_rem_sh;
                    n_root = {r_root[33:0], 1'b0};
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_den  = {72'b0, r_root};
                n_acc  = '0;
                n_rq   = '0;
                n_q    = '0;
                n_qovf = 1'b0;
                unique case (r_pe)
                    3'd0:    n_num = {41'b0, r_in.distance, 16'b0};
                    3'd1:    n_num = 81'b1 << 32;
                    3'd2:    n_num = 81'b1 << 48;
                    3'd3:    n_num = 81'b1 << 64;
                    default: n_num = 81'b1 << 80;
                endcase
                if (r_root == '0 || r_in.distance == '0) begin
                    n_mag   = llrb_pkg::MAG_LIMIT;
                    n_clip  = 1'b1;
                    n_state = S_EMIT_E;
                end else if (r_pe > 3'd1) begin
                    n_mulk  = r_pe - 3'd1;
                    n_cnt   = 7'd23;
                    n_state = S_MUL;
                end else begin
                    n_cnt   = 7'd80;
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                n_acc = w_acc;
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_den  = w_acc;
                    n_acc  = '0;
                    n_mulk = r_mulk - 3'd1;
                    n_cnt  = 7'd23;
                    if (r_mulk == 3'd1) begin
                        n_cnt   = 7'd80;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rq   = w_ge ? w_rs_sub[106:0] : w_rs[106:0];
                n_num  = {r_num[79:0], 1'b0};
                n_q    = w_qf;
                n_qovf = w_qovf;
                n_cnt  = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    if (w_qovf || w_qf > {1'b0, llrb_pkg::MAG_LIMIT}) begin
                        n_mag  = llrb_pkg::MAG_LIMIT;
                        n_clip = 1'b1;
                    end else begin
                        n_mag  = w_qf[47:0];
                        n_clip = 1'b0;
                    end
                    n_state = S_EMIT_E;
                end
            end
            S_EMIT_E: begin
                if (w_out_free) begin
                    n_out.out_row     = r_in.row_index;
                    n_out.out_col     = r_in.col_index;
                    n_out.entry_value = 48'(48'd0 - r_mag);
                    n_out.saturated   = r_clip;
                    n_out.last_of_row = 1'b0;
                    n_ovalid          = 1'b1;
                    n_dclip           = r_dclip || r_clip;
                    if (w_dsum > {1'b0, llrb_pkg::SUM_MAX}) begin
                        n_dsum  = llrb_pkg::SUM_MAX;
                        n_dclip = 1'b1;
                    end else begin
                        n_dsum = w_dsum[47:0];
                    end
                    n_state = r_in.last_in_row ? S_EMIT_D : S_IDLE;
                end
            end
            S_EMIT_D: begin
                if (w_out_free) begin
                    n_out.out_row     = r_in.row_index;
                    n_out.out_col     = r_in.row_index;
                    n_out.entry_value = r_dsum;
                    n_out.saturated   = r_dclip;
                    n_out.last_of_row = 1'b1;
                    n_ovalid          = 1'b1;
                    n_dsum            = '0;
                    n_dclip           = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_p      <= llrb_pkg::P_RESET;
            r_dsum   <= '0;
            r_dclip  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_p      <= n_p;
            r_dsum   <= n_dsum;
            r_dclip  <= n_dclip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_dim    <= n_dim;
        r_in     <= n_in;
        r_pe     <= n_pe;
        r_prod   <= n_prod;
        r_sum_sq <= n_sum_sq;
        r_sqsh   <= n_sqsh;
        r_root   <= n_root;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_acc    <= n_acc;
        r_mulk   <= n_mulk;
        r_num    <= n_num;
        r_rq     <= n_rq;
        r_q      <= n_q;
        r_qovf   <= n_qovf;
        r_mag    <= n_mag;
        r_clip   <= n_clip;
        r_out    <= n_out;
    end

endmodule
`default_nettype wire

/* sv/llrb_checker.sv */
// Port-level assertions for the Laplacian row builder, bound to the top level.
`default_nettype none
module llrb_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_entry_valid,
    input wire logic             i_entry_ready,
    input wire llrb_pkg::t_entry o_entry
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_valid && !i_entry_ready |=> o_entry_valid && $stable(o_entry))
        else $error("entry changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_entry_valid)
        else $error("entry valid after reset");

    a_diag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_valid && o_entry.last_of_row |->
            o_entry.out_row == o_entry.out_col && !o_entry.entry_value[47])
        else $error("bad diagonal entry");

    a_off_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_valid && !o_entry.last_of_row |->
            o_entry.out_row != o_entry.out_col
            && (o_entry.entry_value[47] || o_entry.entry_value == 48'd0))
        else $error("bad off-diagonal entry");

endmodule

bind layout_laplacian_row_builder llrb_checker u_llrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_entry_valid (o_entry_valid),
    .i_entry_ready (i_entry_ready),
    .o_entry       (o_entry)
);
`default_nettype wire
